// ----- sv/rms_pkg.sv -----
// Shared constants, types and helpers of the range-minimum segment tree.
package rms_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int VALUE_BITS   = 32;
  localparam int LEAF_AW      = $clog2(MAX_ELEMENTS);
  localparam int NODE_AW      = LEAF_AW + 1;
  localparam int LEN_W        = 11;
  localparam int POS_W        = 10;
  localparam int DATA_W       = 32;
  localparam int ADDR_W       = 3;

  typedef logic [NODE_AW-1:0]           node_addr_t;
  typedef logic [NODE_AW:0]             bound_t;
  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [LEN_W-1:0]             len_t;
  typedef logic [POS_W-1:0]             pos_t;

  localparam value_t VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

  // Operation codes of an input word.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register word index, taken from paddr[2].
  localparam logic REG_LENGTH = 1'b0;

  // One write port and two read ports of the node memory.
  typedef struct packed {
    logic       we;
    node_addr_t waddr;
    value_t     wdata;
    node_addr_t ra;
    node_addr_t rb;
  } ram_req_t;

  function automatic value_t val_min(value_t a, value_t b);
    return ($signed(b) < $signed(a)) ? b : a;
  endfunction

endpackage

// ----- sv/rms_if.sv -----
// Valid/ready channel interfaces for input words and result words.
interface rms_in_if;
  import rms_pkg::*;
  logic               valid;
  logic               ready;
  logic               operation;
  pos_t               position;
  pos_t               right_bound;
  logic signed [31:0] new_value;
  modport source (output valid, operation, position, right_bound, new_value, input ready);
  modport sink   (input valid, operation, position, right_bound, new_value, output ready);
endinterface

interface rms_out_if;
  logic               valid;
  logic               ready;
  logic               success;
  logic signed [31:0] minimum;
  modport source (output valid, success, minimum, input ready);
  modport sink   (input valid, success, minimum, output ready);
endinterface

// ----- sv/rms_tree_ram.sv -----
// Node memory of the tree: one write port and two registered read ports.
module rms_tree_ram (
  input  logic                clk_i,
  input  rms_pkg::ram_req_t   req_i,
  output rms_pkg::value_t     rd_a_o,
  output rms_pkg::value_t     rd_b_o
);
  import rms_pkg::*;

  value_t mem [2**NODE_AW];
  value_t rd_a_q;
  value_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_a_q <= mem[req_i.ra];
    rd_b_q <= mem[req_i.rb];
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

// ----- sv/rms_cfg.sv -----
// APB-style register block holding the element count in use.
module rms_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rms_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output rms_pkg::len_t              len_o
);
  import rms_pkg::*;

  len_t len_q;
  len_t len_d;
  logic wr_len;

  assign wr_len = psel && penable && pwrite && (paddr[2] == REG_LENGTH);
  assign len_d  = wr_len ? pwdata[LEN_W-1:0] : len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_W'(MAX_ELEMENTS);
    end else begin
      len_q <= len_d;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LENGTH) ? 32'(len_q) : 32'd0;
  assign len_o  = len_q;

endmodule

// ----- sv/rms_seq.sv -----
// Sequencer that walks the tree one level per cycle for updates and queries.
module rms_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  rms_in_if.sink            in_i,
  rms_out_if.source         out_o,
  input  rms_pkg::len_t     len_i,
  output rms_pkg::ram_req_t ram_req_o,
  input  rms_pkg::value_t   rd_a_i,
  input  rms_pkg::value_t   rd_b_i
);
  import rms_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_WLEAF, S_WUP, S_QRUN, S_DONE
  } state_e;

  state_e     state_q, state_d;
  node_addr_t clr_q, clr_d;
  node_addr_t node_q, node_d;
  value_t     cur_q, cur_d;
  bound_t     lo_q, lo_d;
  bound_t     hi_q, hi_d;
  value_t     best_q, best_d;
  logic       pend_a_q, pend_a_d;
  logic       pend_b_q, pend_b_d;
  logic       res_succ_q, res_succ_d;
  value_t     res_min_q, res_min_d;
  logic       out_valid_q, out_valid_d;
  logic       out_succ_q, out_succ_d;
  value_t     out_min_q, out_min_d;

  len_t       eff_len;
  len_t       pos_ext;
  len_t       rb_ext;
  len_t       r_clamp;
  node_addr_t parent;
  bound_t     hi_m1;
  value_t     fold_a;
  value_t     best_fold;
  ram_req_t   req;

  assign eff_len = (len_i > LEN_W'(MAX_ELEMENTS)) ? LEN_W'(MAX_ELEMENTS) : len_i;
  assign pos_ext = LEN_W'(in_i.position);
  assign rb_ext  = LEN_W'(in_i.right_bound);
  assign r_clamp = (rb_ext >= eff_len) ? eff_len - LEN_W'(1) : rb_ext;
  assign parent  = node_q >> 1;
  assign hi_m1   = hi_q - bound_t'(1);

  // Fold the node values read in the previous cycle into the running minimum.
  assign fold_a    = pend_a_q ? val_min(best_q, rd_a_i) : best_q;
  assign best_fold = pend_b_q ? val_min(fold_a, rd_b_i) : fold_a;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    node_d      = node_q;
    cur_d       = cur_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    best_d      = best_q;
    pend_a_d    = pend_a_q;
    pend_b_d    = pend_b_q;
    res_succ_d  = res_succ_q;
    res_min_d   = res_min_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_succ_d  = out_succ_q;
    out_min_d   = out_min_q;
    req         = '0;

    case (state_q)
      S_CLEAR: begin
        req.we    = 1'b1;
        req.waddr = clr_q;
        req.wdata = VALUE_MAX;
        clr_d     = clr_q + NODE_AW'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.operation == OP_WRITE) begin
            if (pos_ext >= eff_len) begin
              res_succ_d = 1'b0;
              res_min_d  = '0;
              state_d    = S_DONE;
            end else begin
              node_d  = NODE_AW'(MAX_ELEMENTS) + NODE_AW'(in_i.position);
              cur_d   = value_t'(in_i.new_value);
              state_d = S_WLEAF;
            end
          end else begin
            if ((in_i.position > in_i.right_bound) || (pos_ext >= eff_len)) begin
              res_succ_d = 1'b0;
              res_min_d  = '0;
              state_d    = S_DONE;
            end else begin
              lo_d     = bound_t'(MAX_ELEMENTS) + bound_t'(in_i.position);
              hi_d     = bound_t'(MAX_ELEMENTS) + bound_t'(r_clamp) + bound_t'(1);
              best_d   = VALUE_MAX;
              pend_a_d = 1'b0;
              pend_b_d = 1'b0;
              state_d  = S_QRUN;
            end
          end
        end
      end
      S_WLEAF: begin
        req.we    = 1'b1;
        req.waddr = node_q;
        req.wdata = cur_q;
        req.ra    = node_q ^ NODE_AW'(1);
        state_d   = S_WUP;
      end
      S_WUP: begin
        // The sibling read last cycle sits on port A; the parent gets the smaller.
        req.we    = 1'b1;
        req.waddr = parent;
        req.wdata = val_min(cur_q, rd_a_i);
        req.ra    = parent ^ NODE_AW'(1);
        cur_d     = val_min(cur_q, rd_a_i);
        node_d    = parent;
        if (parent == NODE_AW'(1)) begin
          res_succ_d = 1'b1;
          res_min_d  = '0;
          state_d    = S_DONE;
        end
      end
      S_QRUN: begin
        best_d = best_fold;
        if (lo_q < hi_q) begin
          req.ra   = lo_q[NODE_AW-1:0];
          req.rb   = hi_m1[NODE_AW-1:0];
          pend_a_d = lo_q[0];
          pend_b_d = hi_q[0];
          lo_d     = (lo_q + bound_t'(lo_q[0])) >> 1;
          hi_d     = hi_q >> 1;
        end else begin
          pend_a_d   = 1'b0;
          pend_b_d   = 1'b0;
          res_succ_d = 1'b1;
          res_min_d  = best_fold;
          state_d    = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_succ_d  = res_succ_q;
          out_min_d   = res_min_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      node_q      <= '0;
      cur_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      best_q      <= '0;
      pend_a_q    <= 1'b0;
      pend_b_q    <= 1'b0;
      res_succ_q  <= 1'b0;
      res_min_q   <= '0;
      out_valid_q <= 1'b0;
      out_succ_q  <= 1'b0;
      out_min_q   <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      node_q      <= node_d;
      cur_q       <= cur_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      best_q      <= best_d;
      pend_a_q    <= pend_a_d;
      pend_b_q    <= pend_b_d;
      res_succ_q  <= res_succ_d;
      res_min_q   <= res_min_d;
      out_valid_q <= out_valid_d;
      out_succ_q  <= out_succ_d;
      out_min_q   <= out_min_d;
    end
  end

  assign ram_req_o     = req;
  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.success = out_succ_q;
  assign out_o.minimum = DATA_W'(out_min_q);

  a_wup_above_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WUP) |-> (node_q >= NODE_AW'(2)))
    else $error("update walk reached the root without finishing");

  a_query_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QRUN) |-> !req.we)
    else $error("node memory written during a query");

  a_query_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QRUN) |-> (lo_q <= hi_q))
    else $error("query bounds crossed");

  a_pend_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_QRUN) |-> (!pend_a_q && !pend_b_q))
    else $error("pending node read outside a query");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken again while a word is in progress");

endmodule

// ----- sv/range_min_segment_tree.sv -----
// Range-minimum segment tree: top level joining registers, sequencer and node memory.
// An update runs from acceptance to a valid result: leaf write, a parent write for each level, unload.
// A query walks up the tree level by level with two node reads per cycle, then unloads.
// Only one word is in progress at a time; the next is taken once the result is registered.
// After reset a clearing pass writes all 2048 nodes, one per cycle, before input is taken.
// Reset sets the element count to 1024; configuration writes are taken at any time.
module range_min_segment_tree (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rms_in_if.sink                     in_i,
  rms_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rms_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import rms_pkg::*;

  len_t     len;
  ram_req_t ram_req;
  value_t   rd_a;
  value_t   rd_b;

  rms_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .len_o   (len)
  );

  rms_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .len_i     (len),
    .ram_req_o (ram_req),
    .rd_a_i    (rd_a),
    .rd_b_i    (rd_b)
  );

  rms_tree_ram u_ram (
    .clk_i  (clk_i),
    .req_i  (ram_req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

endmodule
